[src/nim_pkg.sv]
// shared types, widths and command codes for the node list intersection block
package nim_pkg;

    localparam int PRE_W   = 16;
    localparam int POST_W  = 16;
    localparam int CNT_W   = 24;
    localparam int ENTRY_W = PRE_W + POST_W + CNT_W;

    localparam int LIST_DEPTH_DEF = 64;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] MIN_SUPPORT_RST = CNT_W'(1);

    // input beat commands
    typedef enum logic [1:0] {
        CMD_LOAD_ANC  = 2'd0,
        CMD_LOAD_DESC = 2'd1,
        CMD_RUN       = 2'd2,
        CMD_CLEAR     = 2'd3
    } t_cmd;

    // one list entry as stored in a list memory
    typedef struct packed {
        logic [PRE_W-1:0]  pre;
        logic [POST_W-1:0] post;
        logic [CNT_W-1:0]  cnt;
    } t_entry;

    // operands handed to the shared compare and add unit
    typedef struct packed {
        t_entry            anc;
        t_entry            desc;
        t_entry            pend;
        logic [CNT_W-1:0]  total;
    } t_alu_req;

    // results of the shared compare and add unit
    typedef struct packed {
        logic              anc_before;
        logic              anc_covers;
        logic              same_anc;
        logic [CNT_W-1:0]  cnt_min;
        logic [CNT_W-1:0]  pend_sum;
        logic [CNT_W-1:0]  total_sum;
    } t_alu_res;

endpackage

[src/nim_if.sv]
// valid/ready channel interfaces for input beats and result beats
interface nim_in_if;
    import nim_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [PRE_W-1:0]  pre_index;
    logic [POST_W-1:0] post_index;
    logic [CNT_W-1:0]  node_count;

    modport source (output valid, command, pre_index, post_index, node_count, input ready);
    modport sink   (input valid, command, pre_index, post_index, node_count, output ready);
endinterface

interface nim_out_if;
    import nim_pkg::*;

    logic              valid;
    logic              ready;
    logic [PRE_W-1:0]  out_pre;
    logic [POST_W-1:0] out_post;
    logic [CNT_W-1:0]  out_count;
    logic              is_last;
    logic              is_empty;
    logic [CNT_W-1:0]  total_support;
    logic              is_frequent;

    modport source (output valid, out_pre, out_post, out_count, is_last, is_empty,
                    total_support, is_frequent, input ready);
    modport sink   (input valid, out_pre, out_post, out_count, is_last, is_empty,
                    total_support, is_frequent, output ready);
endinterface

[src/nim_ram.sv]
// generic single write port ram with one registered read port
module nim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/nim_alu.sv]
// shared merge step unit: containment compare, count minimum and saturating adds
module nim_alu (
    input  nim_pkg::t_alu_req i_req,
    output nim_pkg::t_alu_res o_res
);
    import nim_pkg::*;

    logic [CNT_W-1:0] cnt_min;
    logic [CNT_W:0]   pend_wide;
    logic [CNT_W:0]   total_wide;

    // smaller of the two node counts
    assign cnt_min = (i_req.anc.cnt < i_req.desc.cnt) ? i_req.anc.cnt : i_req.desc.cnt;

    // saturating accumulations for the pending result and the running total
    assign pend_wide  = {1'b0, i_req.pend.cnt} + {1'b0, cnt_min};
    assign total_wide = {1'b0, i_req.total} + {1'b0, cnt_min};

    always_comb begin
        o_res.anc_before = i_req.anc.pre < i_req.desc.pre;
        o_res.anc_covers = i_req.anc.post > i_req.desc.post;
        o_res.same_anc   = (i_req.pend.pre == i_req.anc.pre) &&
                           (i_req.pend.post == i_req.anc.post);
        o_res.cnt_min    = cnt_min;
        o_res.pend_sum   = pend_wide[CNT_W] ? CNT_MAX : pend_wide[CNT_W-1:0];
        o_res.total_sum  = total_wide[CNT_W] ? CNT_MAX : total_wide[CNT_W-1:0];
    end

endmodule

[src/nlist_intersect_merge_top.sv]
// Node list intersection for PrePost mining. Load beats (ancestor or descendant
// entry) append to their list and the clear beat empties both; a load into a full
// list is dropped. A run beat walks both lists with two pointers; each merge step
// is a read state and a compare state (the list memories have one registered read
// port each), and a flush state then sends the final result. The walk takes at
// most ancestor length + descendant length - 1 steps. A compare stalls while a
// finished result finds no free result slot, and the flush waits for one too.
// Input ready is low for the whole run. Results of the same ancestor are merged
// before they leave; the last result carries the saturating total support and the
// frequent flag, and an empty intersection yields one result marked empty and last.
module nlist_intersect_merge_top #(
    parameter int LIST_DEPTH = nim_pkg::LIST_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    nim_in_if.sink                   i_in,
    nim_out_if.source                o_out,
    input  logic                     i_cfg_we,
    input  logic [nim_pkg::CNT_W-1:0] i_cfg_data
);
    import nim_pkg::*;

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int LW = $clog2(LIST_DEPTH + 1);
    localparam logic [LW-1:0] DEPTH_L = LW'(LIST_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_FLUSH
    } t_state;

    t_state r_state, n_state;

    logic [LW-1:0]    r_alen, n_alen;
    logic [LW-1:0]    r_dlen, n_dlen;
    logic [LW-1:0]    r_i, n_i;
    logic [LW-1:0]    r_j, n_j;
    logic [CNT_W-1:0] r_min_sup;
    t_entry           r_pend, n_pend;
    logic             r_have_pend, n_have_pend;
    logic [CNT_W-1:0] r_total, n_total;

    // result register
    logic              r_o_valid, n_o_valid;
    logic [PRE_W-1:0]  r_o_pre, n_o_pre;
    logic [POST_W-1:0] r_o_post, n_o_post;
    logic [CNT_W-1:0]  r_o_count, n_o_count;
    logic              r_o_last, n_o_last;
    logic              r_o_empty, n_o_empty;
    logic [CNT_W-1:0]  r_o_total, n_o_total;
    logic              r_o_freq, n_o_freq;

    logic             in_fire;
    t_cmd             cmd;
    t_entry           in_entry;
    logic             anc_we;
    logic             desc_we;
    logic [ENTRY_W-1:0] anc_rdata;
    logic [ENTRY_W-1:0] desc_rdata;
    t_alu_req         alu_req;
    t_alu_res         alu_res;
    logic             out_free;
    logic             match;
    logic             stall;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign cmd        = t_cmd'(i_in.command);

    assign in_entry.pre  = i_in.pre_index;
    assign in_entry.post = i_in.post_index;
    assign in_entry.cnt  = i_in.node_count;

    // list writes at the current fill position
    assign anc_we  = in_fire && (cmd == CMD_LOAD_ANC) && (r_alen < DEPTH_L);
    assign desc_we = in_fire && (cmd == CMD_LOAD_DESC) && (r_dlen < DEPTH_L);

    nim_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LIST_DEPTH)
    ) u_anc_ram (
        .i_clk   (i_clk),
        .i_we    (anc_we),
        .i_waddr (r_alen[AW-1:0]),
        .i_wdata (in_entry),
        .i_raddr (r_i[AW-1:0]),
        .o_rdata (anc_rdata)
    );

    nim_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LIST_DEPTH)
    ) u_desc_ram (
        .i_clk   (i_clk),
        .i_we    (desc_we),
        .i_waddr (r_dlen[AW-1:0]),
        .i_wdata (in_entry),
        .i_raddr (r_j[AW-1:0]),
        .o_rdata (desc_rdata)
    );

    // shared compare and add unit
    assign alu_req.anc   = t_entry'(anc_rdata);
    assign alu_req.desc  = t_entry'(desc_rdata);
    assign alu_req.pend  = r_pend;
    assign alu_req.total = r_total;

    nim_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    assign out_free = !r_o_valid || o_out.ready;
    assign match    = alu_res.anc_before && alu_res.anc_covers;
    // a new ancestor pushes the pending one out, which needs a free result slot
    assign stall    = match && r_have_pend && !alu_res.same_anc && !out_free;

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_alen      = r_alen;
        n_dlen      = r_dlen;
        n_i         = r_i;
        n_j         = r_j;
        n_pend      = r_pend;
        n_have_pend = r_have_pend;
        n_total     = r_total;
        n_o_valid   = r_o_valid;
        n_o_pre     = r_o_pre;
        n_o_post    = r_o_post;
        n_o_count   = r_o_count;
        n_o_last    = r_o_last;
        n_o_empty   = r_o_empty;
        n_o_total   = r_o_total;
        n_o_freq    = r_o_freq;

        if (r_o_valid && o_out.ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (cmd)
                        CMD_LOAD_ANC: begin
                            if (r_alen < DEPTH_L) begin
                                n_alen = r_alen + LW'(1);
                            end
                        end
                        CMD_LOAD_DESC: begin
                            if (r_dlen < DEPTH_L) begin
                                n_dlen = r_dlen + LW'(1);
                            end
                        end
                        CMD_RUN: begin
                            n_i         = '0;
                            n_j         = '0;
                            n_have_pend = 1'b0;
                            n_total     = '0;
                            n_state     = ((r_alen == '0) || (r_dlen == '0)) ? S_FLUSH : S_RD;
                        end
                        CMD_CLEAR: begin
                            n_alen = '0;
                            n_dlen = '0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (!stall) begin
                    if (match) begin
                        if (r_have_pend && alu_res.same_anc) begin
                            n_pend.cnt = alu_res.pend_sum;
                        end else begin
                            // pending result is final, send it on
                            if (r_have_pend) begin
                                n_o_valid = 1'b1;
                                n_o_pre   = r_pend.pre;
                                n_o_post  = r_pend.post;
                                n_o_count = r_pend.cnt;
                                n_o_last  = 1'b0;
                                n_o_empty = 1'b0;
                                n_o_total = '0;
                                n_o_freq  = 1'b0;
                            end
                            n_pend.pre  = alu_req.anc.pre;
                            n_pend.post = alu_req.anc.post;
                            n_pend.cnt  = alu_res.cnt_min;
                            n_have_pend = 1'b1;
                        end
                        n_total = alu_res.total_sum;
                        n_j     = r_j + LW'(1);
                    end else if (alu_res.anc_before) begin
                        n_i = r_i + LW'(1);
                    end else begin
                        n_j = r_j + LW'(1);
                    end
                    n_state = ((n_i >= r_alen) || (n_j >= r_dlen)) ? S_FLUSH : S_RD;
                end
            end
            S_FLUSH: begin
                // last beat of the run, or the empty marker
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_pre   = r_have_pend ? r_pend.pre : '0;
                    n_o_post  = r_have_pend ? r_pend.post : '0;
                    n_o_count = r_have_pend ? r_pend.cnt : '0;
                    n_o_last  = 1'b1;
                    n_o_empty = !r_have_pend;
                    n_o_total = r_total;
                    n_o_freq  = r_total >= r_min_sup;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, control and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_alen      <= '0;
            r_dlen      <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_have_pend <= 1'b0;
            r_total     <= '0;
            r_o_valid   <= 1'b0;
            r_min_sup   <= MIN_SUPPORT_RST;
        end else begin
            r_state     <= n_state;
            r_alen      <= n_alen;
            r_dlen      <= n_dlen;
            r_i         <= n_i;
            r_j         <= n_j;
            r_have_pend <= n_have_pend;
            r_total     <= n_total;
            r_o_valid   <= n_o_valid;
            if (i_cfg_we) begin
                r_min_sup <= i_cfg_data;
            end
        end
        r_pend    <= n_pend;
        r_o_pre   <= n_o_pre;
        r_o_post  <= n_o_post;
        r_o_count <= n_o_count;
        r_o_last  <= n_o_last;
        r_o_empty <= n_o_empty;
        r_o_total <= n_o_total;
        r_o_freq  <= n_o_freq;
    end

    assign o_out.valid         = r_o_valid;
    assign o_out.out_pre       = r_o_pre;
    assign o_out.out_post      = r_o_post;
    assign o_out.out_count     = r_o_count;
    assign o_out.is_last       = r_o_last;
    assign o_out.is_empty      = r_o_empty;
    assign o_out.total_support = r_o_total;
    assign o_out.is_frequent   = r_o_freq;

endmodule

[src/nim_checker.sv]
// port level checks for the node list intersection block, bound to the top level
module nim_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic [1:0]                i_in_command,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [nim_pkg::PRE_W-1:0] i_out_pre,
    input logic [nim_pkg::CNT_W-1:0] i_out_count,
    input logic                      i_out_last,
    input logic                      i_out_empty,
    input logic [nim_pkg::CNT_W-1:0] i_out_total,
    input logic                      i_out_freq
);
    import nim_pkg::*;

    // a result beat waits until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // an empty marker is the last beat and carries zeros
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_empty |->
            i_out_last && (i_out_pre == '0) && (i_out_count == '0) && (i_out_total == '0))
        else $error("empty result is not a zero last beat");

    // only the last beat carries support and the frequent flag
    a_mid_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> (i_out_total == '0) && !i_out_freq && !i_out_empty)
        else $error("non-last result carries summary fields");

    // a run beat blocks the input side on the next cycle
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_command == CMD_RUN) |=> !i_in_ready)
        else $error("input accepted straight after a run beat");

endmodule

bind nlist_intersect_merge_top nim_checker u_nim_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_command (i_in.command),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_pre    (o_out.out_pre),
    .i_out_count  (o_out.out_count),
    .i_out_last   (o_out.is_last),
    .i_out_empty  (o_out.is_empty),
    .i_out_total  (o_out.total_support),
    .i_out_freq   (o_out.is_frequent)
);
